FILE: rtl/core/gbpt_pkg.sv
package gbpt_pkg;

    localparam int VERTICES_DEF     = 1024;
    localparam int BUCKET_SLOTS_DEF = 4096;

    localparam int VID_W     = 10;
    localparam int GAIN_W    = 12;
    localparam int WEIGHT_W  = 16;
    localparam int ROOM_W    = 20;
    localparam int BOUND_W   = 11;
    localparam int COUNT_W   = 11;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;

    localparam logic [BOUND_W-1:0] BOUND_RESET = 11'd2047;

    typedef enum logic [2:0] {
        MODE_PLACE     = 3'd0,
        MODE_REMOVE    = 3'd1,
        MODE_PICK_TOP  = 3'd2,
        MODE_PICK_DESC = 3'd3,
        MODE_CLEAR     = 3'd4
    } mode_t;

    typedef enum logic {
        CFG_INSERT_ORDER = 1'b0,
        CFG_GAIN_BOUND   = 1'b1
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_V_RD,
        ST_V_EVAL,
        ST_UN_HEAD,
        ST_UN_TAIL,
        ST_UN_SELF,
        ST_INS_RD,
        ST_INS_EVAL,
        ST_INS_LINK,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_PK_BRD,
        ST_PK_BEVAL,
        ST_PK_NRD,
        ST_PK_NEVAL,
        ST_CLR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic prev;
        logic next;
        logic linked;
        logic loc;
        logic weight;
    } node_mask_t;

    typedef struct packed {
        logic head;
        logic tail;
    } bucket_mask_t;

    function automatic logic [GAIN_W-1:0] sat_gain(input logic signed [17:0] x);
        logic [GAIN_W-1:0] r;
        if (x > 18'sd2047)
            r = 12'h7ff;
        else if (x < -18'sd2048)
            r = 12'h800;
        else
            r = x[GAIN_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/gbpt_store.sv
module gbpt_store #(
    parameter int VERTICES     = gbpt_pkg::VERTICES_DEF,
    parameter int BUCKET_SLOTS = gbpt_pkg::BUCKET_SLOTS_DEF,
    localparam int AW = (VERTICES > 1) ? $clog2(VERTICES) : 1,
    localparam int NW = $clog2(VERTICES + 1),
    localparam int SW = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1,
    localparam int BW = SW + 1
) (
    input  logic                          clk,
    // node table
    input  logic [AW-1:0]                 node_raddr,
    input  logic                          node_we,
    input  logic [AW-1:0]                 node_waddr,
    input  gbpt_pkg::node_mask_t          node_wmask,
    input  logic [NW-1:0]                 node_wprev,
    input  logic [NW-1:0]                 node_wnext,
    input  logic                          node_wlinked,
    input  logic                          node_wside,
    input  logic [SW-1:0]                 node_wslot,
    input  logic [gbpt_pkg::WEIGHT_W-1:0] node_wweight,
    output logic [NW-1:0]                 node_rprev,
    output logic [NW-1:0]                 node_rnext,
    output logic                          node_rlinked,
    output logic                          node_rside,
    output logic [SW-1:0]                 node_rslot,
    output logic [gbpt_pkg::WEIGHT_W-1:0] node_rweight,
    // bucket table, addressed by {side, slot}
    input  logic [BW-1:0]                 bkt_raddr,
    input  logic                          bkt_we,
    input  logic [BW-1:0]                 bkt_waddr,
    input  gbpt_pkg::bucket_mask_t        bkt_wmask,
    input  logic [NW-1:0]                 bkt_whead,
    input  logic [NW-1:0]                 bkt_wtail,
    output logic [NW-1:0]                 bkt_rhead,
    output logic [NW-1:0]                 bkt_rtail
);
    import gbpt_pkg::*;

    localparam int BDEPTH = 2 * (2 ** SW);

    logic [NW-1:0]       prev_mem   [VERTICES];
    logic [NW-1:0]       next_mem   [VERTICES];
    logic                linked_mem [VERTICES];
    logic                side_mem   [VERTICES];
    logic [SW-1:0]       slot_mem   [VERTICES];
    logic [WEIGHT_W-1:0] weight_mem [VERTICES];
    logic [NW-1:0]       head_mem   [BDEPTH];
    logic [NW-1:0]       tail_mem   [BDEPTH];

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            if (node_wmask.prev)   prev_mem[node_waddr]   <= node_wprev;
            if (node_wmask.next)   next_mem[node_waddr]   <= node_wnext;
            if (node_wmask.linked) linked_mem[node_waddr] <= node_wlinked;
            if (node_wmask.loc)
            begin
                side_mem[node_waddr] <= node_wside;
                slot_mem[node_waddr] <= node_wslot;
            end
            if (node_wmask.weight) weight_mem[node_waddr] <= node_wweight;
        end
        node_rprev   <= prev_mem[node_raddr];
        node_rnext   <= next_mem[node_raddr];
        node_rlinked <= linked_mem[node_raddr];
        node_rside   <= side_mem[node_raddr];
        node_rslot   <= slot_mem[node_raddr];
        node_rweight <= weight_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            if (bkt_wmask.head) head_mem[bkt_waddr] <= bkt_whead;
            if (bkt_wmask.tail) tail_mem[bkt_waddr] <= bkt_wtail;
        end
        bkt_rhead <= head_mem[bkt_raddr];
        bkt_rtail <= tail_mem[bkt_raddr];
    end

endmodule

FILE: rtl/core/gain_bucket_priority_table_unit.sv
// Gain bucket table for min-cut partitioning, two sides of doubly linked
// per-gain vertex lists kept in a node memory and a bucket memory.
// Input channel s_*: one item per operation (place, remove, pick top,
// pick descending, clear side). Output channel m_*: exactly one result
// item per input item, in order. Config channel cfg_*: insert order and
// gain bound, always ready; write only while the unit is idle.
// Place reads the vertex, unlinks it first when it is linked, then links it
// into its bucket; remove unlinks a linked vertex; either may then rescan
// the buckets downward for the max gain. Pick top walks the top bucket's
// vertices, pick descending walks down through the buckets; clear empties
// the side's buckets and unlinks that side's nodes. The node and bucket
// memories take one read and one write per cycle each, with registered
// read data.
// One item is in work at a time; s_tready is high only when idle.
// Reset starts a clearing pass over max(VERTICES, 2 * 2**clog2(BUCKET_SLOTS))
// entries (8192 at default size) during which no item is accepted.
// A result waits in the output register while m_tready is low; the next
// item is accepted and worked on, and it finishes once that slot frees.
module gain_bucket_priority_table_unit #(
    parameter int VERTICES     = gbpt_pkg::VERTICES_DEF,
    parameter int BUCKET_SLOTS = gbpt_pkg::BUCKET_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vertex[9:0], gain[21:10], weight[37:22], room[57:38], zero fill
    input  logic [gbpt_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode[2:0], side[3]
    input  logic [3:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // picked_vertex[9:0], picked_gain[21:10], top_gain[33:22],
    // side_count[44:34], zero fill
    output logic [gbpt_pkg::OUT_DATA_W-1:0] m_tdata,
    // found[0]
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [gbpt_pkg::BOUND_W-1:0]    cfg_data
);
    import gbpt_pkg::*;

    localparam int AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int NW = $clog2(VERTICES + 1);
    localparam int SW = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int BW = SW + 1;
    localparam int CLR_LEN  = (VERTICES > BUCKET_SLOTS) ? VERTICES : BUCKET_SLOTS;
    localparam int BDEPTH   = 2 * (2 ** SW);
    localparam int INIT_LEN = (VERTICES > BDEPTH) ? VERTICES : BDEPTH;
    localparam int KW = $clog2(INIT_LEN + 1);
    localparam logic [NW-1:0] NIL = NW'(VERTICES);

    state_t               state_reg, state_next;
    logic                 order_reg, order_next;
    logic [BOUND_W-1:0]   bound_reg, bound_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [SW-1:0]        max_reg [2];
    logic [SW-1:0]        max_next [2];
    logic [NW-1:0]        cnt_reg [2];
    logic [NW-1:0]        cnt_next [2];
    logic                 m_tvalid_reg, m_tvalid_next;

    mode_t                mode_reg, mode_next;
    logic                 side_reg, side_next;
    logic [NW-1:0]        v_reg, v_next;
    logic [SW-1:0]        idx_reg, idx_next;
    logic [WEIGHT_W-1:0]  w_reg, w_next;
    logic [ROOM_W-1:0]    room_reg, room_next;
    logic [NW-1:0]        vp_reg, vp_next;
    logic [NW-1:0]        vn_reg, vn_next;
    logic                 os_reg, os_next;
    logic [SW-1:0]        oslot_reg, oslot_next;
    logic [NW-1:0]        lnk_reg, lnk_next;
    logic [SW-1:0]        e_reg, e_next;
    logic [NW-1:0]        c_reg, c_next;
    logic                 found_reg, found_next;
    logic [NW-1:0]        pv_reg, pv_next;
    logic [SW-1:0]        pe_reg, pe_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    logic [AW-1:0]        node_raddr, node_waddr;
    logic                 node_we;
    node_mask_t           node_wmask;
    logic [NW-1:0]        node_wprev, node_wnext;
    logic                 node_wlinked, node_wside;
    logic [SW-1:0]        node_wslot;
    logic [WEIGHT_W-1:0]  node_wweight;
    logic [NW-1:0]        nd_prev, nd_next;
    logic                 nd_linked, nd_side;
    logic [SW-1:0]        nd_slot;
    logic [WEIGHT_W-1:0]  nd_weight;
    logic [BW-1:0]        bkt_raddr, bkt_waddr;
    logic                 bkt_we;
    bucket_mask_t         bkt_wmask;
    logic [NW-1:0]        bkt_whead, bkt_wtail;
    logic [NW-1:0]        bk_head, bk_tail;

    // slot of the incoming gain
    logic signed [GAIN_W-1:0] in_gain, gbs, gclamp;
    logic [12:0]              in_sum;
    logic [SW-1:0]            in_idx;
    logic [VID_W-1:0]         in_vertex;
    logic                     in_vok;

    always_comb
    begin
        in_vertex = s_tdata[9:0];
        in_gain   = $signed(s_tdata[21:10]);
        gbs       = $signed({1'b0, bound_reg});
        if (in_gain > gbs)
            gclamp = gbs;
        else if (in_gain < -gbs)
            gclamp = -gbs;
        else
            gclamp = in_gain;
        in_sum = 13'({gclamp[GAIN_W-1], gclamp}) + 13'({2'b00, bound_reg});
        if (17'(in_sum) > 17'(BUCKET_SLOTS - 1))
            in_idx = SW'(BUCKET_SLOTS - 1);
        else
            in_idx = SW'(in_sum);
        in_vok = 17'(in_vertex) < 17'(VERTICES);
    end

    gbpt_store #(
        .VERTICES     (VERTICES),
        .BUCKET_SLOTS (BUCKET_SLOTS)
    ) u_store (
        .clk          (clk),
        .node_raddr   (node_raddr),
        .node_we      (node_we),
        .node_waddr   (node_waddr),
        .node_wmask   (node_wmask),
        .node_wprev   (node_wprev),
        .node_wnext   (node_wnext),
        .node_wlinked (node_wlinked),
        .node_wside   (node_wside),
        .node_wslot   (node_wslot),
        .node_wweight (node_wweight),
        .node_rprev   (nd_prev),
        .node_rnext   (nd_next),
        .node_rlinked (nd_linked),
        .node_rside   (nd_side),
        .node_rslot   (nd_slot),
        .node_rweight (nd_weight),
        .bkt_raddr    (bkt_raddr),
        .bkt_we       (bkt_we),
        .bkt_waddr    (bkt_waddr),
        .bkt_wmask    (bkt_wmask),
        .bkt_whead    (bkt_whead),
        .bkt_wtail    (bkt_wtail),
        .bkt_rhead    (bk_head),
        .bkt_rtail    (bk_tail)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb
    begin
        state_next    = state_reg;
        order_next    = order_reg;
        bound_next    = bound_reg;
        k_next        = k_reg;
        max_next      = max_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        mode_next     = mode_reg;
        side_next     = side_reg;
        v_next        = v_reg;
        idx_next      = idx_reg;
        w_next        = w_reg;
        room_next     = room_reg;
        vp_next       = vp_reg;
        vn_next       = vn_reg;
        os_next       = os_reg;
        oslot_next    = oslot_reg;
        lnk_next      = lnk_reg;
        e_next        = e_reg;
        c_next        = c_reg;
        found_next    = found_reg;
        pv_next       = pv_reg;
        pe_next       = pe_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        node_raddr   = '0;
        node_we      = 1'b0;
        node_waddr   = '0;
        node_wmask   = '0;
        node_wprev   = NIL;
        node_wnext   = NIL;
        node_wlinked = 1'b0;
        node_wside   = side_reg;
        node_wslot   = idx_reg;
        node_wweight = w_reg;
        bkt_raddr    = '0;
        bkt_we       = 1'b0;
        bkt_waddr    = '0;
        bkt_wmask    = '0;
        bkt_whead    = NIL;
        bkt_wtail    = NIL;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_INSERT_ORDER: order_next = cfg_data[0];
                CFG_GAIN_BOUND:   bound_next = cfg_data;
                default:          ;
            endcase
        end

        case (state_reg)
            ST_INIT:
            begin
                if (k_reg < KW'(BDEPTH))
                begin
                    bkt_we    = 1'b1;
                    bkt_waddr = BW'(k_reg);
                    bkt_wmask = '{head: 1'b1, tail: 1'b1};
                end
                if (k_reg < KW'(VERTICES))
                begin
                    node_we    = 1'b1;
                    node_waddr = AW'(k_reg);
                    node_wmask = '{prev: 1'b1, next: 1'b1, linked: 1'b1,
                                   loc: 1'b0, weight: 1'b0};
                end
                if (k_reg == KW'(INIT_LEN - 1))
                    state_next = ST_IDLE;
                else
                    k_next = k_reg + 1'b1;
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = mode_t'(s_tuser[2:0]);
                    side_next  = s_tuser[3];
                    v_next     = NW'(in_vertex);
                    idx_next   = in_idx;
                    w_next     = s_tdata[37:22];
                    room_next  = s_tdata[57:38];
                    found_next = 1'b0;
                    pv_next    = '0;
                    pe_next    = '0;
                    e_next     = max_reg[s_tuser[3]];
                    k_next     = '0;
                    case (mode_t'(s_tuser[2:0]))
                        MODE_PLACE, MODE_REMOVE:
                            state_next = in_vok ? ST_V_RD : ST_DONE;
                        MODE_PICK_TOP:
                            state_next = (cnt_reg[s_tuser[3]] == '0) ? ST_DONE : ST_PK_BRD;
                        MODE_PICK_DESC:
                            state_next = ST_PK_BRD;
                        MODE_CLEAR:
                            state_next = ST_CLR;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end

            ST_V_RD:
            begin
                node_raddr = AW'(v_reg);
                state_next = ST_V_EVAL;
            end

            ST_V_EVAL:
            begin
                vp_next    = nd_prev;
                vn_next    = nd_next;
                os_next    = nd_side;
                oslot_next = nd_slot;
                if (nd_linked)
                begin
                    if (mode_reg == MODE_REMOVE || nd_side != side_reg)
                        cnt_next[nd_side] = (cnt_reg[nd_side] == '0) ? '0
                                            : cnt_reg[nd_side] - 1'b1;
                    if (mode_reg == MODE_PLACE && nd_side != side_reg)
                        cnt_next[side_reg] = cnt_reg[side_reg] + 1'b1;
                    state_next = ST_UN_HEAD;
                end
                else if (mode_reg == MODE_PLACE)
                begin
                    cnt_next[side_reg] = cnt_reg[side_reg] + 1'b1;
                    state_next = ST_INS_RD;
                end
                else
                    state_next = ST_DONE;
            end

            ST_UN_HEAD:
            begin
                if (vp_reg == NIL)
                begin
                    bkt_we    = 1'b1;
                    bkt_waddr = {os_reg, oslot_reg};
                    bkt_wmask = '{head: 1'b1, tail: 1'b0};
                    bkt_whead = vn_reg;
                end
                else
                begin
                    node_we    = 1'b1;
                    node_waddr = AW'(vp_reg);
                    node_wmask = '{prev: 1'b0, next: 1'b1, linked: 1'b0,
                                   loc: 1'b0, weight: 1'b0};
                    node_wnext = vn_reg;
                end
                state_next = ST_UN_TAIL;
            end

            ST_UN_TAIL:
            begin
                if (vn_reg == NIL)
                begin
                    bkt_we    = 1'b1;
                    bkt_waddr = {os_reg, oslot_reg};
                    bkt_wmask = '{head: 1'b0, tail: 1'b1};
                    bkt_wtail = vp_reg;
                end
                else
                begin
                    node_we    = 1'b1;
                    node_waddr = AW'(vn_reg);
                    node_wmask = '{prev: 1'b1, next: 1'b0, linked: 1'b0,
                                   loc: 1'b0, weight: 1'b0};
                    node_wprev = vp_reg;
                end
                state_next = ST_UN_SELF;
            end

            ST_UN_SELF:
            begin
                node_we    = 1'b1;
                node_waddr = AW'(v_reg);
                node_wmask = '{prev: 1'b1, next: 1'b1, linked: 1'b1,
                               loc: 1'b0, weight: 1'b0};
                if (mode_reg == MODE_PLACE)
                    state_next = ST_INS_RD;
                else if (max_reg[side_reg] == idx_reg)
                begin
                    e_next     = idx_reg;
                    state_next = ST_SCAN_RD;
                end
                else
                    state_next = ST_DONE;
            end

            ST_INS_RD:
            begin
                bkt_raddr = {side_reg, idx_reg};
                if (idx_reg > max_reg[side_reg])
                    max_next[side_reg] = idx_reg;
                state_next = ST_INS_EVAL;
            end

            ST_INS_EVAL:
            begin
                node_we      = 1'b1;
                node_waddr   = AW'(v_reg);
                node_wmask   = '{prev: 1'b1, next: 1'b1, linked: 1'b1,
                                 loc: 1'b1, weight: 1'b1};
                node_wlinked = 1'b1;
                bkt_we       = 1'b1;
                bkt_waddr    = {side_reg, idx_reg};
                bkt_whead    = v_reg;
                bkt_wtail    = v_reg;
                if (order_reg)
                begin
                    node_wprev = bk_tail;
                    bkt_wmask  = '{head: (bk_tail == NIL), tail: 1'b1};
                    lnk_next   = bk_tail;
                end
                else
                begin
                    node_wnext = bk_head;
                    bkt_wmask  = '{head: 1'b1, tail: (bk_head == NIL)};
                    lnk_next   = bk_head;
                end
                if ((order_reg ? bk_tail : bk_head) != NIL)
                    state_next = ST_INS_LINK;
                else if (max_reg[side_reg] > idx_reg)
                begin
                    e_next     = max_reg[side_reg];
                    state_next = ST_SCAN_RD;
                end
                else
                    state_next = ST_DONE;
            end

            ST_INS_LINK:
            begin
                node_we    = 1'b1;
                node_waddr = AW'(lnk_reg);
                node_wmask = '{prev: !order_reg, next: order_reg, linked: 1'b0,
                               loc: 1'b0, weight: 1'b0};
                node_wprev = v_reg;
                node_wnext = v_reg;
                if (max_reg[side_reg] > idx_reg)
                begin
                    e_next     = max_reg[side_reg];
                    state_next = ST_SCAN_RD;
                end
                else
                    state_next = ST_DONE;
            end

            ST_SCAN_RD:
            begin
                bkt_raddr  = {side_reg, e_reg};
                state_next = ST_SCAN_EVAL;
            end

            ST_SCAN_EVAL:
            begin
                // stop at entry zero even when it is empty
                if (bk_head == NIL && e_reg != '0)
                begin
                    e_next     = e_reg - 1'b1;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    max_next[side_reg] = e_reg;
                    state_next = ST_DONE;
                end
            end

            ST_PK_BRD:
            begin
                bkt_raddr  = {side_reg, e_reg};
                state_next = ST_PK_BEVAL;
            end

            ST_PK_BEVAL:
            begin
                if (bk_head == NIL)
                begin
                    if (mode_reg == MODE_PICK_DESC && e_reg != '0)
                    begin
                        e_next     = e_reg - 1'b1;
                        state_next = ST_PK_BRD;
                    end
                    else
                        state_next = ST_DONE;
                end
                else
                begin
                    c_next     = bk_head;
                    state_next = ST_PK_NRD;
                end
            end

            ST_PK_NRD:
            begin
                node_raddr = AW'(c_reg);
                state_next = ST_PK_NEVAL;
            end

            ST_PK_NEVAL:
            begin
                if (ROOM_W'(nd_weight) <= room_reg)
                begin
                    found_next = 1'b1;
                    pv_next    = c_reg;
                    pe_next    = e_reg;
                    state_next = ST_DONE;
                end
                else if (nd_next == NIL)
                begin
                    if (mode_reg == MODE_PICK_DESC && e_reg != '0)
                    begin
                        e_next     = e_reg - 1'b1;
                        state_next = ST_PK_BRD;
                    end
                    else
                        state_next = ST_DONE;
                end
                else
                begin
                    c_next     = nd_next;
                    state_next = ST_PK_NRD;
                end
            end

            ST_CLR:
            begin
                // sweep: empty this side's buckets, unlink its nodes one behind the read
                if (k_reg < KW'(BUCKET_SLOTS))
                begin
                    bkt_we    = 1'b1;
                    bkt_waddr = {side_reg, SW'(k_reg)};
                    bkt_wmask = '{head: 1'b1, tail: 1'b1};
                end
                node_raddr = AW'(k_reg);
                if (k_reg != '0 && (k_reg - 1'b1) < KW'(VERTICES) && nd_linked
                    && nd_side == side_reg)
                begin
                    node_we    = 1'b1;
                    node_waddr = AW'(k_reg - 1'b1);
                    node_wmask = '{prev: 1'b1, next: 1'b1, linked: 1'b1,
                                   loc: 1'b0, weight: 1'b0};
                end
                if (k_reg == KW'(CLR_LEN))
                begin
                    cnt_next[side_reg] = '0;
                    state_next = ST_DONE;
                end
                else
                    k_next = k_reg + 1'b1;
            end

            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = found_reg;
                    m_tdata_next  = {3'b000,
                                     COUNT_W'(cnt_reg[side_reg]),
                                     sat_gain($signed(18'(max_reg[side_reg]))
                                              - $signed(18'(bound_reg))),
                                     found_reg ? sat_gain($signed(18'(pe_reg))
                                                          - $signed(18'(bound_reg)))
                                               : {GAIN_W{1'b0}},
                                     VID_W'(pv_reg)};
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            order_reg    <= 1'b0;
            bound_reg    <= BOUND_RESET;
            k_reg        <= '0;
            max_reg[0]   <= '0;
            max_reg[1]   <= '0;
            cnt_reg[0]   <= '0;
            cnt_reg[1]   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            order_reg    <= order_next;
            bound_reg    <= bound_next;
            k_reg        <= k_next;
            max_reg      <= max_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        side_reg    <= side_next;
        v_reg       <= v_next;
        idx_reg     <= idx_next;
        w_reg       <= w_next;
        room_reg    <= room_next;
        vp_reg      <= vp_next;
        vn_reg      <= vn_next;
        os_reg      <= os_next;
        oslot_reg   <= oslot_next;
        lnk_reg     <= lnk_next;
        e_reg       <= e_next;
        c_reg       <= c_next;
        found_reg   <= found_next;
        pv_reg      <= pv_next;
        pe_reg      <= pe_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (17'(cnt_reg[0]) <= 17'(VERTICES)) && (17'(cnt_reg[1]) <= 17'(VERTICES)))
        else $error("side count above vertex count");

    a_max_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (17'(max_reg[0]) < 17'(BUCKET_SLOTS)) && (17'(max_reg[1]) < 17'(BUCKET_SLOTS)))
        else $error("max-gain pointer beyond bucket range");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while busy");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

endmodule

FILE: verif/gain_bucket_priority_table_unit_tb.sv
module gain_bucket_priority_table_unit_tb;
    import gbpt_pkg::*;

    localparam int NV    = VERTICES_DEF;
    localparam int NS    = BUCKET_SLOTS_DEF;
    localparam int NIL   = NV;
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID   = 3'd6;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [2:0]  mode;
        logic        side;
        logic [9:0]  vtx;
        logic [11:0] gain;
        logic [15:0] weight;
        logic [19:0] room;
    } op_item_t;

    typedef struct {
        logic        found;
        logic [9:0]  pvtx;
        logic [11:0] pgain;
        logic [11:0] top;
        logic [10:0] count;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [3:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = CFG_INSERT_ORDER;
    logic [BOUND_W-1:0] cfg_data = '0;

    gain_bucket_priority_table_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // shadow table
    int  node_prev [NV];
    int  node_next [NV];
    bit  node_linked [NV];
    int  node_weight [NV];
    int  node_bucket [NV];
    int  bucket_head [2*NS];
    int  bucket_tail [2*NS];
    int  max_entry [2];
    int  held_count [2];
    bit  fifo_order = 1'b0;
    int  bound = 2047;

    op_item_t      pending_ops[$];
    table_result_t expected_results[$];
    int  errors = 0;
    int  results_seen = 0;
    int  picks_found = 0;
    int  items_sent = 0;

    // generator-side guesses of where each vertex sits
    int  last_gain [NV];
    bit  last_side [NV];

    function automatic logic [11:0] sat12(int x);
        if (x > 2047) x = 2047;
        if (x < -2048) x = -2048;
        return x[11:0];
    endfunction

    function automatic int slot_of(int g);
        if (g > bound) g = bound;
        if (g < -bound) g = -bound;
        g = g + bound;
        if (g > NS - 1) g = NS - 1;
        return g;
    endfunction

    function automatic void unlink_vtx(int v);
        int b, p, n;
        b = node_bucket[v];
        p = node_prev[v];
        n = node_next[v];
        if (p == NIL) bucket_head[b] = n; else node_next[p] = n;
        if (n == NIL) bucket_tail[b] = p; else node_prev[n] = p;
        node_prev[v] = NIL;
        node_next[v] = NIL;
        node_linked[v] = 0;
    endfunction

    function automatic void link_vtx(int v, int b);
        int t;
        if (fifo_order) begin
            t = bucket_tail[b];
            node_next[v] = NIL;
            node_prev[v] = t;
            if (t == NIL) bucket_head[b] = v; else node_next[t] = v;
            bucket_tail[b] = v;
        end else begin
            t = bucket_head[b];
            node_prev[v] = NIL;
            node_next[v] = t;
            if (t == NIL) bucket_tail[b] = v; else node_prev[t] = v;
            bucket_head[b] = v;
        end
        node_bucket[v] = b;
        node_linked[v] = 1;
    endfunction

    function automatic void rescan(int s, int start);
        int e;
        e = start;
        while (e > 0 && bucket_head[s*NS + e] == NIL) e--;
        max_entry[s] = e;
    endfunction

    function automatic table_result_t apply_op(op_item_t it);
        table_result_t r;
        int s, v, g, idx, os, e, c, pg, i;
        s = int'(it.side);
        v = int'(it.vtx);
        g = $signed(it.gain);
        r.found = 1'b0;
        r.pvtx = '0;
        pg = 0;
        case (it.mode)
            MODE_PLACE: begin
                idx = slot_of(g);
                if (node_linked[v]) begin
                    os = node_bucket[v] / NS;
                    unlink_vtx(v);
                    if (os != s) begin
                        if (held_count[os] > 0) held_count[os]--;
                        held_count[s]++;
                    end
                end else begin
                    held_count[s]++;
                end
                node_weight[v] = int'(it.weight);
                if (idx > max_entry[s]) max_entry[s] = idx;
                link_vtx(v, s*NS + idx);
                if (max_entry[s] > idx) rescan(s, max_entry[s]);
            end
            MODE_REMOVE: begin
                if (node_linked[v]) begin
                    os = node_bucket[v] / NS;
                    idx = slot_of(g);
                    unlink_vtx(v);
                    if (held_count[os] > 0) held_count[os]--;
                    if (max_entry[s] == idx) rescan(s, idx);
                end
            end
            MODE_PICK_TOP: begin
                if (held_count[s] > 0) begin
                    e = max_entry[s];
                    c = bucket_head[s*NS + e];
                    for (i = 0; i < NV && c != NIL; i++) begin
                        if (node_weight[c] <= int'(it.room)) begin
                            r.found = 1'b1;
                            r.pvtx = c[9:0];
                            pg = e - bound;
                            break;
                        end
                        c = node_next[c];
                    end
                end
            end
            MODE_PICK_DESC: begin
                e = max_entry[s];
                c = bucket_head[s*NS + e];
                forever begin
                    while (c == NIL && e > 0) begin
                        e--;
                        c = bucket_head[s*NS + e];
                    end
                    if (c == NIL) break;
                    if (node_weight[c] <= int'(it.room)) begin
                        r.found = 1'b1;
                        r.pvtx = c[9:0];
                        pg = e - bound;
                        break;
                    end
                    c = node_next[c];
                end
            end
            MODE_CLEAR: begin
                for (i = 0; i < NV; i++)
                    if (node_linked[i] && node_bucket[i] / NS == s) begin
                        node_linked[i] = 0;
                        node_prev[i] = NIL;
                        node_next[i] = NIL;
                    end
                for (i = 0; i < NS; i++) begin
                    bucket_head[s*NS + i] = NIL;
                    bucket_tail[s*NS + i] = NIL;
                end
                held_count[s] = 0;
            end
            default: ;
        endcase
        r.pgain = r.found ? sat12(pg) : 12'd0;
        r.top = sat12(max_entry[s] - bound);
        r.count = held_count[s][10:0];
        return r;
    endfunction

    // input side driver
    logic in_fire = 1'b0;
    int   in_gap = 0;
    bit   no_idle = 0;

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (no_idle || k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk) in_fire <= s_tvalid && s_tready;

    always @(negedge clk) begin
        op_item_t it;
        if ($urandom_range(0, 199) == 0) no_idle = ~no_idle;
        if (rst_n && (!s_tvalid || in_fire)) begin
            if (in_gap > 0) begin
                in_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                it = pending_ops.pop_front();
                s_tdata <= {6'd0, it.room, it.weight, it.gain, it.vtx};
                s_tuser <= {it.side, it.mode};
                s_tvalid <= 1'b1;
                in_gap = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output side ready pattern
    int out_stall = 0;
    always @(negedge clk) begin
        if (out_stall > 0) begin
            out_stall--;
            m_tready <= 1'b0;
        end else begin
            out_stall = pick_gap();
            m_tready <= (out_stall == 0);
        end
    end

    // predict on accepted items and config writes, check results
    always @(posedge clk) begin
        op_item_t      it;
        table_result_t want, got;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_INSERT_ORDER) fifo_order = cfg_data[0];
            else bound = int'(cfg_data);
        end
        if (s_tvalid && s_tready) begin
            it.vtx    = s_tdata[9:0];
            it.gain   = s_tdata[21:10];
            it.weight = s_tdata[37:22];
            it.room   = s_tdata[57:38];
            it.mode   = s_tuser[2:0];
            it.side   = s_tuser[3];
            expected_results.push_back(apply_op(it));
            items_sent++;
        end
        if (m_tvalid && m_tready) begin
            got.found = m_tuser;
            got.pvtx  = m_tdata[9:0];
            got.pgain = m_tdata[21:10];
            got.top   = m_tdata[33:22];
            got.count = m_tdata[44:34];
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: found=%0d v=%0d pg=%h top=%h cnt=%0d",
                             got.found, got.pvtx, got.pgain, got.top, got.count);
            end else begin
                want = expected_results.pop_front();
                if (want.found) picks_found++;
                if (got.found !== want.found || got.pvtx !== want.pvtx ||
                    got.pgain !== want.pgain || got.top !== want.top ||
                    got.count !== want.count) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch #%0d: exp found=%0d v=%0d pg=%h top=%h cnt=%0d, got found=%0d v=%0d pg=%h top=%h cnt=%0d",
                                 results_seen, want.found, want.pvtx, want.pgain, want.top,
                                 want.count, got.found, got.pvtx, got.pgain, got.top,
                                 got.count);
                end
            end
        end
    end

    task automatic add_op(logic [2:0] mode, logic side, int v, int g, int w, int room);
        op_item_t it;
        it.mode = mode;
        it.side = side;
        it.vtx = v[9:0];
        it.gain = g[11:0];
        it.weight = w[15:0];
        it.room = room[19:0];
        if (mode == MODE_PLACE) begin
            last_gain[v[9:0]] = g;
            last_side[v[9:0]] = side;
        end
        pending_ops.push_back(it);
    endtask

    task automatic add_random_op(int pool);
        int k, v, g, span;
        logic [2:0] mode;
        logic side;
        k = $urandom_range(0, 999);
        if (k < 450) mode = MODE_PLACE;
        else if (k < 650) mode = MODE_REMOVE;
        else if (k < 810) mode = MODE_PICK_TOP;
        else if (k < 975) mode = MODE_PICK_DESC;
        else if (k < 985) mode = MODE_CLEAR;
        else mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NV - 1) : $urandom_range(0, pool - 1);
        side = 1'($urandom_range(0, 1));
        span = (bound > 20) ? 20 : bound + 3;
        if ($urandom_range(0, 9) < 8) g = $urandom_range(0, 2*span) - span;
        else g = $urandom_range(0, 4095);
        if (mode == MODE_REMOVE && $urandom_range(0, 9) < 8) begin
            g = last_gain[v];
            side = last_side[v];
        end
        add_op(mode, side, v, g,
               ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1000) : $urandom_range(0, 65535),
               ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1200) : $urandom_range(0, 1048575));
    endtask

    task automatic wait_idle();
        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[BOUND_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(bit order, int bnd, int items, int pool);
        wait_idle();
        write_reg(CFG_INSERT_ORDER, order);
        write_reg(CFG_GAIN_BOUND, bnd);
        repeat (items) add_random_op(pool);
    endtask

    initial begin
        int i;
        for (i = 0; i < NV; i++) begin
            node_prev[i] = NIL;
            node_next[i] = NIL;
            node_linked[i] = 0;
            node_weight[i] = 0;
            node_bucket[i] = 0;
            last_gain[i] = 0;
            last_side[i] = 0;
        end
        for (i = 0; i < 2*NS; i++) begin
            bucket_head[i] = NIL;
            bucket_tail[i] = NIL;
        end
        max_entry = '{0, 0};
        held_count = '{0, 0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at reset settings: extremes and corner cases
        add_op(MODE_PLACE, 0, 0, 2047, 65535, 0);
        add_op(MODE_PLACE, 0, 1023, -2047, 0, 0);
        add_op(MODE_PLACE, 1, 5, 0, 300, 0);
        add_op(MODE_PLACE, 0, 6, -2048, 200, 0);
        add_op(MODE_PLACE, 0, 5, 1, 300, 0);
        add_op(MODE_PICK_TOP, 0, 0, 0, 0, 0);
        add_op(MODE_PICK_TOP, 0, 0, 0, 0, 1048575);
        add_op(MODE_PICK_DESC, 0, 0, 0, 0, 0);
        add_op(MODE_PICK_DESC, 0, 0, 0, 0, 299);
        add_op(MODE_REMOVE, 0, 0, 2047, 0, 0);
        add_op(MODE_REMOVE, 0, 7, 0, 0, 0);
        add_op(MODE_REMOVE, 1, 1023, -2047, 0, 0);
        add_op(MODE_PICK_TOP, 1, 0, 0, 0, 1048575);
        add_op(MODE_PICK_DESC, 1, 0, 0, 0, 1048575);
        add_op(MODE_SPARE_FIRST, 0, 0, 0, 0, 0);
        add_op(MODE_SPARE_MID, 1, 1023, 2047, 65535, 1048575);
        add_op(MODE_SPARE_LAST, 0, 0, 0, 0, 0);
        add_op(MODE_CLEAR, 0, 0, 0, 0, 0);
        add_op(MODE_PICK_DESC, 0, 0, 0, 0, 1048575);
        add_op(MODE_PLACE, 0, 9, 3, 10, 0);
        add_op(MODE_PICK_TOP, 0, 0, 0, 0, 10);

        run_phase(1, 15, 300, 32);
        run_phase(0, 0, 150, 16);
        run_phase(1, 2047, 60, 24);
        run_phase(0, 100, 300, 48);
        run_phase(1, 7, 290, 20);

        wait_idle();
        repeat (20) @(negedge clk);
        $display("Ran %0d items over five bound/order settings, %0d results checked, %0d picks hit",
                 items_sent, results_seen, picks_found);
        if (errors == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #50000000;
        $display("Timeout: %0d results still expected", expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
